// File: design/rkc_pkg.sv
`timescale 1ns / 1ps

package rkc_pkg;

  // image and kernel store geometry
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int MAX_KERNEL = 7;
  localparam int COEFF_FRAC = 12;

  localparam int COORD_W  = 6;
  localparam int COMP_W   = 16;
  localparam int COEFF_W  = 16;
  localparam int DIM_W    = 7;
  localparam int KDIM_W   = 3;
  localparam int BPC_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam int XADDR_W = $clog2(MAX_WIDTH);
  localparam int YADDR_W = $clog2(MAX_HEIGHT);
  localparam int PIX_AW  = XADDR_W + YADDR_W;
  localparam int PIX_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int KIDX_W  = $clog2(MAX_KERNEL);
  localparam int KDEPTH  = MAX_KERNEL * MAX_KERNEL;
  localparam int KADDR_W = $clog2(KDEPTH);

  // product: unsigned component times signed coefficient
  localparam int PROD_W = COMP_W + 1 + COEFF_W;
  // accumulator: room for every tap at full magnitude
  localparam int ACC_W  = PROD_W + $clog2(KDEPTH) + 1;

  localparam logic [COMP_W-1:0] COMP_MAX_NARROW = 16'd255;
  localparam logic [COMP_W-1:0] COMP_MAX_WIDE   = 16'd65535;

  // operation codes
  localparam logic [1:0] OP_LOAD_COEFF = 2'd0;
  localparam logic [1:0] OP_WRITE_PIX  = 2'd1;
  localparam logic [1:0] OP_COMPUTE    = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_COMP = 3'd6;

  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;

endpackage

// File: design/rgb_kernel_convolution_core.sv
`timescale 1ns / 1ps
// timing: load-coefficient, write-pixel and rejected items give their result in the cycle
// after the transfer; a compute item walks n = kernel_width * kernel_height taps (1 to 49)
// at one tap read and one shared three-lane multiply-accumulate per cycle, via registered
// reads, products and sums, then waits for a free output. one item is in work at a time.
// reset: registers return to their reset values, the kernel store reads as all zero,
// the pixel store holds no defined data until written.
module rgb_kernel_convolution_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [rkc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [rkc_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [1:0]                           op_i,
  input  logic [rkc_pkg::COORD_W-1:0]          col_i,
  input  logic [rkc_pkg::COORD_W-1:0]          row_i,
  input  logic [rkc_pkg::COMP_W-1:0]           red_in_i,
  input  logic [rkc_pkg::COMP_W-1:0]           green_in_i,
  input  logic [rkc_pkg::COMP_W-1:0]           blue_in_i,
  input  logic signed [rkc_pkg::COEFF_W-1:0]   coeff_value_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [rkc_pkg::COMP_W-1:0]           red_out_o,
  output logic [rkc_pkg::COMP_W-1:0]           green_out_o,
  output logic [rkc_pkg::COMP_W-1:0]           blue_out_o,
  output logic                                 status_o
);

  localparam int CW   = rkc_pkg::COMP_W;
  localparam int PW   = rkc_pkg::PROD_W;
  localparam int AW   = rkc_pkg::ACC_W;
  localparam int XW   = rkc_pkg::XADDR_W;
  localparam int YW   = rkc_pkg::YADDR_W;
  localparam int KW   = rkc_pkg::KIDX_W;
  localparam int KAW  = rkc_pkg::KADDR_W;
  localparam int SW   = rkc_pkg::COORD_W + 3; // signed tap coordinate

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  // configuration registers
  logic [rkc_pkg::DIM_W-1:0]  image_width_q, image_height_q;
  logic [rkc_pkg::KDIM_W-1:0] kernel_width_q, kernel_height_q;
  logic [rkc_pkg::KDIM_W-1:0] center_x_q, center_y_q;
  logic [rkc_pkg::BPC_W-1:0]  bpc_q;

  // effective dimensions
  logic [rkc_pkg::DIM_W-1:0]  w_eff, h_eff, w_m1, h_m1;
  logic [rkc_pkg::KDIM_W-1:0] kw_eff, kh_eff;
  logic                       wide_comp;
  logic [CW-1:0]              comp_max;

  // sequencer and tap counters
  logic [1:0]    state_q, state_d;
  logic [rkc_pkg::COORD_W-1:0] col_q, row_q;
  logic [KW-1:0] tap_i_q, tap_j_q;
  logic          issue_done_q;
  logic          issue_act, issue_last;

  // memories
  logic [3*CW-1:0] pix_mem [rkc_pkg::PIX_DEPTH];
  logic [3*CW-1:0] pix_rd_q;
  logic [rkc_pkg::COEFF_W-1:0] kmem [rkc_pkg::KDEPTH];
  logic [rkc_pkg::COEFF_W-1:0] kmem_rd_q;
  logic [rkc_pkg::KDEPTH-1:0]  kvalid_q;
  logic            kvalid_rd_q;

  // pipeline flags
  logic rd_v_q, rd_last_q, prod_v_q, prod_last_q;

  // shared multiply-accumulate lanes
  logic signed [rkc_pkg::COEFF_W-1:0] coef;
  logic signed [PW-1:0] prod_r_q, prod_g_q, prod_b_q;
  logic signed [AW-1:0] acc_r_q, acc_g_q, acc_b_q;

  // output register
  logic          out_valid_q;
  logic [CW-1:0] red_q, green_q, blue_q;
  logic          status_q;

  // accept-side decode
  logic          in_xfer, out_free;
  logic          bad_kernel, bad_pixel, item_error;
  logic          kwrite, pwrite, start_compute;
  logic [KAW-1:0] kwaddr, kraddr;
  logic [rkc_pkg::PIX_AW-1:0] pwaddr, praddr;
  logic [CW-1:0] red_sat, green_sat, blue_sat;

  // tap coordinate generation
  logic signed [SW-1:0] xs, ys;
  logic [XW-1:0] tap_x;
  logic [YW-1:0] tap_y;

  // finishing
  logic [CW-1:0] fin_r, fin_g, fin_b;

  function automatic logic [CW-1:0] finish_sum(input logic signed [AW-1:0] acc,
                                               input logic [CW-1:0] maxv);
    logic [AW-rkc_pkg::COEFF_FRAC-1:0] sh;
    begin
      sh = acc[AW-1:rkc_pkg::COEFF_FRAC];
      if (acc[AW-1] || acc == '0) begin
        finish_sum = '0;
      end else if (sh > (AW-rkc_pkg::COEFF_FRAC)'(maxv)) begin
        finish_sum = maxv;
      end else begin
        finish_sum = sh[CW-1:0];
      end
    end
  endfunction

  // ---------------------------------------------------------------------
  // effective register values: out-of-range values saturate
  // ---------------------------------------------------------------------
  always_comb begin
    if (image_width_q == '0) begin
      w_eff = 7'd1;
    end else if (image_width_q > 7'(rkc_pkg::MAX_WIDTH)) begin
      w_eff = 7'(rkc_pkg::MAX_WIDTH);
    end else begin
      w_eff = image_width_q;
    end
    if (image_height_q == '0) begin
      h_eff = 7'd1;
    end else if (image_height_q > 7'(rkc_pkg::MAX_HEIGHT)) begin
      h_eff = 7'(rkc_pkg::MAX_HEIGHT);
    end else begin
      h_eff = image_height_q;
    end
    kw_eff = (kernel_width_q == '0) ? 3'd1 : kernel_width_q;
    kh_eff = (kernel_height_q == '0) ? 3'd1 : kernel_height_q;
  end

  assign w_m1      = w_eff - 7'd1;
  assign h_m1      = h_eff - 7'd1;
  // size codes 2 and 3 mean two bytes, 0 and 1 mean one
  assign wide_comp = bpc_q[1];
  assign comp_max  = wide_comp ? rkc_pkg::COMP_MAX_WIDE : rkc_pkg::COMP_MAX_NARROW;

  // ---------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q   <= 7'd64;
      image_height_q  <= 7'd64;
      kernel_width_q  <= 3'd1;
      kernel_height_q <= 3'd1;
      center_x_q      <= '0;
      center_y_q      <= '0;
      bpc_q           <= 2'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rkc_pkg::REG_IMAGE_WIDTH:    image_width_q   <= cfg_data_i;
        rkc_pkg::REG_IMAGE_HEIGHT:   image_height_q  <= cfg_data_i;
        rkc_pkg::REG_KERNEL_WIDTH:   kernel_width_q  <= cfg_data_i[2:0];
        rkc_pkg::REG_KERNEL_HEIGHT:  kernel_height_q <= cfg_data_i[2:0];
        rkc_pkg::REG_CENTER_X:       center_x_q      <= cfg_data_i[2:0];
        rkc_pkg::REG_CENTER_Y:       center_y_q      <= cfg_data_i[2:0];
        rkc_pkg::REG_BYTES_PER_COMP: bpc_q           <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // input decode: loads and writes finish in the transfer cycle,
  // a compute item hands off to the tap sequencer
  // ---------------------------------------------------------------------
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign bad_kernel = (col_i >= 6'(rkc_pkg::MAX_KERNEL)) ||
                      (row_i >= 6'(rkc_pkg::MAX_KERNEL));
  assign bad_pixel  = ({1'b0, col_i} >= w_eff) || ({1'b0, row_i} >= h_eff);

  always_comb begin
    case (op_i)
      rkc_pkg::OP_LOAD_COEFF: item_error = bad_kernel;
      rkc_pkg::OP_WRITE_PIX:  item_error = bad_pixel;
      rkc_pkg::OP_COMPUTE:    item_error = bad_pixel;
      default:                item_error = 1'b1;
    endcase
  end

  assign kwrite        = in_xfer && (op_i == rkc_pkg::OP_LOAD_COEFF) && !item_error;
  assign pwrite        = in_xfer && (op_i == rkc_pkg::OP_WRITE_PIX) && !item_error;
  assign start_compute = in_xfer && (op_i == rkc_pkg::OP_COMPUTE) && !item_error;

  // kernel store is row-major with a stride of the kernel maximum
  assign kwaddr = KAW'(row_i) * KAW'(rkc_pkg::MAX_KERNEL) + KAW'(col_i);
  assign pwaddr = {row_i[YW-1:0], col_i[XW-1:0]};

  // components saturate to the current size before storing
  assign red_sat   = (red_in_i   > comp_max) ? comp_max : red_in_i;
  assign green_sat = (green_in_i > comp_max) ? comp_max : green_in_i;
  assign blue_sat  = (blue_in_i  > comp_max) ? comp_max : blue_in_i;

  // ---------------------------------------------------------------------
  // tap walk: clamp-to-edge neighbor coordinate
  // ---------------------------------------------------------------------
  assign xs = $signed({3'b000, col_q}) - $signed({6'b0, center_x_q})
            + $signed({6'b0, tap_i_q});
  assign ys = $signed({3'b000, row_q}) - $signed({6'b0, center_y_q})
            + $signed({6'b0, tap_j_q});

  always_comb begin
    if (xs < 0) begin
      tap_x = '0;
    end else if (xs > $signed({2'b00, w_m1})) begin
      tap_x = w_m1[XW-1:0];
    end else begin
      tap_x = xs[XW-1:0];
    end
    if (ys < 0) begin
      tap_y = '0;
    end else if (ys > $signed({2'b00, h_m1})) begin
      tap_y = h_m1[YW-1:0];
    end else begin
      tap_y = ys[YW-1:0];
    end
  end

  assign praddr = {tap_y, tap_x};
  assign kraddr = KAW'(tap_j_q) * KAW'(rkc_pkg::MAX_KERNEL) + KAW'(tap_i_q);

  assign issue_act  = (state_q == ST_RUN) && !issue_done_q;
  assign issue_last = (tap_i_q == kw_eff - 3'd1) && (tap_j_q == kh_eff - 3'd1);

  // ---------------------------------------------------------------------
  // memories: one write and one registered read each
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (pwrite) begin
      pix_mem[pwaddr] <= {red_sat, green_sat, blue_sat};
    end
    pix_rd_q <= pix_mem[praddr];
  end

  always_ff @(posedge clk_i) begin
    if (kwrite) begin
      kmem[kwaddr] <= coeff_value_i;
    end
    kmem_rd_q <= kmem[kraddr];
  end

  // per-entry valid bits give the all-zero kernel after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kvalid_q    <= '0;
      kvalid_rd_q <= 1'b0;
    end else begin
      if (kwrite) begin
        kvalid_q[kwaddr] <= 1'b1;
      end
      kvalid_rd_q <= kvalid_q[kraddr];
    end
  end

  assign coef = kvalid_rd_q ? $signed(kmem_rd_q) : '0;

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start_compute) state_d = ST_RUN;
      ST_RUN:  if (prod_v_q && prod_last_q) state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      tap_i_q      <= '0;
      tap_j_q      <= '0;
      issue_done_q <= 1'b0;
      rd_v_q       <= 1'b0;
      rd_last_q    <= 1'b0;
      prod_v_q     <= 1'b0;
      prod_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_v_q      <= issue_act;
      rd_last_q   <= issue_act && issue_last;
      prod_v_q    <= rd_v_q;
      prod_last_q <= rd_last_q;
      if (start_compute) begin
        tap_i_q      <= '0;
        tap_j_q      <= '0;
        issue_done_q <= 1'b0;
      end else if (issue_act) begin
        // rows inner, columns outer
        if (issue_last) begin
          issue_done_q <= 1'b1;
        end else if (tap_j_q == kh_eff - 3'd1) begin
          tap_j_q <= '0;
          tap_i_q <= tap_i_q + 3'd1;
        end else begin
          tap_j_q <= tap_j_q + 3'd1;
        end
      end
    end
  end

  // output coordinate held for the whole walk
  always_ff @(posedge clk_i) begin
    if (start_compute) begin
      col_q <= col_i;
      row_q <= row_i;
    end
  end

  // ---------------------------------------------------------------------
  // shared multiply-accumulate: three component lanes, product registered
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    prod_r_q <= $signed({1'b0, pix_rd_q[3*CW-1:2*CW]}) * coef;
    prod_g_q <= $signed({1'b0, pix_rd_q[2*CW-1:CW]})   * coef;
    prod_b_q <= $signed({1'b0, pix_rd_q[CW-1:0]})      * coef;
    if (start_compute) begin
      acc_r_q <= '0;
      acc_g_q <= '0;
      acc_b_q <= '0;
    end else if (prod_v_q) begin
      acc_r_q <= acc_r_q + AW'(prod_r_q);
      acc_g_q <= acc_g_q + AW'(prod_g_q);
      acc_b_q <= acc_b_q + AW'(prod_b_q);
    end
  end

  // truncate toward zero, then saturate to the component range
  assign fin_r = finish_sum(acc_r_q, comp_max);
  assign fin_g = finish_sum(acc_g_q, comp_max);
  assign fin_b = finish_sum(acc_b_q, comp_max);

  // ---------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer && !start_compute) begin
      out_valid_q <= 1'b1;
    end else if (state_q == ST_FIN && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && !start_compute) begin
      // loads, writes and rejected items carry zero components
      red_q    <= '0;
      green_q  <= '0;
      blue_q   <= '0;
      status_q <= item_error ? rkc_pkg::STATUS_ERROR : rkc_pkg::STATUS_DONE;
    end else if (state_q == ST_FIN && out_free) begin
      red_q    <= fin_r;
      green_q  <= fin_g;
      blue_q   <= fin_b;
      status_q <= rkc_pkg::STATUS_DONE;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = red_q;
  assign green_out_o = green_q;
  assign blue_out_o  = blue_q;
  assign status_o    = status_q;

endmodule

// File: dv/rgb_kernel_convolution_core_test.sv
`timescale 1ns / 1ps

module rgb_kernel_convolution_core_test;

  // package constants used here
  localparam int MAX_WIDTH  = rkc_pkg::MAX_WIDTH;
  localparam int MAX_HEIGHT = rkc_pkg::MAX_HEIGHT;
  localparam int MAX_KERNEL = rkc_pkg::MAX_KERNEL;
  localparam int COEFF_FRAC = rkc_pkg::COEFF_FRAC;
  localparam int COORD_W    = rkc_pkg::COORD_W;
  localparam int COMP_W     = rkc_pkg::COMP_W;
  localparam int COEFF_W    = rkc_pkg::COEFF_W;
  localparam int DIM_W      = rkc_pkg::DIM_W;
  localparam int KDIM_W     = rkc_pkg::KDIM_W;
  localparam int BPC_W      = rkc_pkg::BPC_W;
  localparam int CFG_IDX_W  = rkc_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = rkc_pkg::CFG_DATA_W;
  localparam int PIX_DEPTH  = rkc_pkg::PIX_DEPTH;
  localparam int KDEPTH     = rkc_pkg::KDEPTH;
  localparam logic [COMP_W-1:0] COMP_MAX_NARROW = rkc_pkg::COMP_MAX_NARROW;
  localparam logic [COMP_W-1:0] COMP_MAX_WIDE   = rkc_pkg::COMP_MAX_WIDE;
  localparam logic [1:0] OP_LOAD_COEFF = rkc_pkg::OP_LOAD_COEFF;
  localparam logic [1:0] OP_WRITE_PIX  = rkc_pkg::OP_WRITE_PIX;
  localparam logic [1:0] OP_COMPUTE    = rkc_pkg::OP_COMPUTE;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = rkc_pkg::REG_IMAGE_WIDTH;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = rkc_pkg::REG_IMAGE_HEIGHT;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH   = rkc_pkg::REG_KERNEL_WIDTH;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT  = rkc_pkg::REG_KERNEL_HEIGHT;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X       = rkc_pkg::REG_CENTER_X;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y       = rkc_pkg::REG_CENTER_Y;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_COMP = rkc_pkg::REG_BYTES_PER_COMP;
  localparam logic STATUS_DONE  = rkc_pkg::STATUS_DONE;
  localparam logic STATUS_ERROR = rkc_pkg::STATUS_ERROR;

  // codes the package leaves unnamed
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  localparam int COORD_MAX = (1 << COORD_W) - 1;
  localparam int CYCLE_LIMIT = 1_000_000;
  // longest compute is 49 taps plus the pipeline
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [1:0]               op;
    logic [COORD_W-1:0]       col;
    logic [COORD_W-1:0]       row;
    logic [COMP_W-1:0]        red;
    logic [COMP_W-1:0]        green;
    logic [COMP_W-1:0]        blue;
    logic signed [COEFF_W-1:0] coeff;
    int                       gap;    // idle cycles before the item is offered
    bit                       drain;  // offer only once every result is back
  } conv_req_t;

  typedef struct {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
    logic              status;
  } conv_res_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               op = '0;
  logic [COORD_W-1:0]       col = '0;
  logic [COORD_W-1:0]       row = '0;
  logic [COMP_W-1:0]        red_in = '0;
  logic [COMP_W-1:0]        green_in = '0;
  logic [COMP_W-1:0]        blue_in = '0;
  logic signed [COEFF_W-1:0] coeff_value = '0;

  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [COMP_W-1:0]        red_out;
  logic [COMP_W-1:0]        green_out;
  logic [COMP_W-1:0]        blue_out;
  logic                     status;

  rgb_kernel_convolution_core dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .op_i          (op),
    .col_i         (col),
    .row_i         (row),
    .red_in_i      (red_in),
    .green_in_i    (green_in),
    .blue_in_i     (blue_in),
    .coeff_value_i (coeff_value),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .red_out_o     (red_out),
    .green_out_o   (green_out),
    .blue_out_o    (blue_out),
    .status_o      (status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // register shadow, written only while the block is idle, so the generator and
  // the predictor can share it
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0]  sh_iw = 7'd64;
  logic [DIM_W-1:0]  sh_ih = 7'd64;
  logic [KDIM_W-1:0] sh_kw = 3'd1;
  logic [KDIM_W-1:0] sh_kh = 3'd1;
  logic [KDIM_W-1:0] sh_cx = 3'd0;
  logic [KDIM_W-1:0] sh_cy = 3'd0;
  logic [BPC_W-1:0]  sh_bpc = 2'd1;

  // predicted store contents
  logic [COMP_W-1:0]         px_red   [PIX_DEPTH];
  logic [COMP_W-1:0]         px_green [PIX_DEPTH];
  logic [COMP_W-1:0]         px_blue  [PIX_DEPTH];
  logic signed [COEFF_W-1:0] coeff_store [KDEPTH];

  // pixels written so far, tracked in stimulus order so no compute reads junk
  bit pix_known [PIX_DEPTH];

  conv_req_t req_q[$];
  conv_res_t expected_px_q[$];
  conv_req_t cur_req;
  conv_req_t nxt;
  bit        have_next = 1'b0;

  int  gen_count = 0;
  int  fail_count = 0;
  int  cycle_count = 0;
  int  rx_wait = 0;
  int  rx_taken = 0;
  bit  hold_go = 1'b0;
  logic rx_hold = 1'b0;

  initial begin
    for (int k = 0; k < KDEPTH; k++) coeff_store[k] = '0;
  end

  function automatic int clip(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // out-of-range register values are pulled into the legal range
  function automatic int eff_dim(int raw, int limit);
    return clip(raw, 1, limit);
  endfunction

  function automatic int cur_w();
    return eff_dim(int'(sh_iw), MAX_WIDTH);
  endfunction

  function automatic int cur_h();
    return eff_dim(int'(sh_ih), MAX_HEIGHT);
  endfunction

  function automatic int comp_limit();
    return (sh_bpc >= 2'd2) ? int'(COMP_MAX_WIDE) : int'(COMP_MAX_NARROW);
  endfunction

  function automatic logic [COMP_W-1:0] sat_comp(logic [COMP_W-1:0] v);
    return (int'(v) > comp_limit()) ? COMP_W'(comp_limit()) : v;
  endfunction

  // drop the fraction bits, then saturate into the component range
  function automatic logic [COMP_W-1:0] clip_sum(longint acc);
    longint v;
    if (acc <= 0) return '0;
    v = acc >>> COEFF_FRAC;
    return (v > longint'(comp_limit())) ? COMP_W'(comp_limit()) : COMP_W'(v);
  endfunction

  // applies one accepted item to the predicted state, returns its result
  function automatic conv_res_t apply_request(conv_req_t rq);
    conv_res_t rs;
    int w, h, kw, kh, x, y, a;
    longint acc_r, acc_g, acc_b, k;
    rs.red = '0;
    rs.green = '0;
    rs.blue = '0;
    rs.status = STATUS_DONE;
    w = cur_w();
    h = cur_h();
    case (rq.op)
      OP_LOAD_COEFF: begin
        if (rq.col >= MAX_KERNEL || rq.row >= MAX_KERNEL) rs.status = STATUS_ERROR;
        else coeff_store[rq.row * MAX_KERNEL + rq.col] = rq.coeff;
      end
      OP_WRITE_PIX: begin
        if (rq.col >= w || rq.row >= h) begin
          rs.status = STATUS_ERROR;
        end else begin
          a = rq.row * MAX_WIDTH + rq.col;
          px_red[a] = sat_comp(rq.red);
          px_green[a] = sat_comp(rq.green);
          px_blue[a] = sat_comp(rq.blue);
        end
      end
      OP_COMPUTE: begin
        if (rq.col >= w || rq.row >= h) begin
          rs.status = STATUS_ERROR;
        end else begin
          kw = eff_dim(int'(sh_kw), MAX_KERNEL);
          kh = eff_dim(int'(sh_kh), MAX_KERNEL);
          acc_r = 0;
          acc_g = 0;
          acc_b = 0;
          for (int i = 0; i < kw; i++) begin
            for (int j = 0; j < kh; j++) begin
              // clamp-to-edge neighbour
              x = clip(int'(rq.col) - int'(sh_cx) + i, 0, w - 1);
              y = clip(int'(rq.row) - int'(sh_cy) + j, 0, h - 1);
              a = y * MAX_WIDTH + x;
              k = longint'(coeff_store[j * MAX_KERNEL + i]);
              acc_r += longint'(px_red[a]) * k;
              acc_g += longint'(px_green[a]) * k;
              acc_b += longint'(px_blue[a]) * k;
            end
          end
          rs.red = clip_sum(acc_r);
          rs.green = clip_sum(acc_g);
          rs.blue = clip_sum(acc_b);
        end
      end
      default: rs.status = STATUS_ERROR;
    endcase
    return rs;
  endfunction

  function automatic void check_field(string field, int expd, int got);
    if (expd != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expd, got);
      fail_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: one transfer per item, gap drawn per item
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : tx_side
    if (rst_n) begin
      if (in_valid && in_ready) expected_px_q.push_back(apply_request(cur_req));
      if (!in_valid || in_ready) begin
        if (!have_next && req_q.size() != 0) begin
          nxt = req_q.pop_front();
          have_next = 1'b1;
        end
        if (!have_next || (nxt.drain && expected_px_q.size() != 0)) begin
          in_valid <= 1'b0;
        end else if (nxt.gap > 0) begin
          nxt.gap--;
          in_valid <= 1'b0;
        end else begin
          cur_req = nxt;
          have_next = 1'b0;
          in_valid <= 1'b1;
          op <= nxt.op;
          col <= nxt.col;
          row <= nxt.row;
          red_in <= nxt.red;
          green_in <= nxt.green;
          blue_in <= nxt.blue;
          coeff_value <= nxt.coeff;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: compare each result transfer with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : rx_side
    conv_res_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_px_q.size() == 0) begin
          $display("%0t: result with none expected, actual %0d %0d %0d status %0d",
                   $time, red_out, green_out, blue_out, status);
          fail_count++;
        end else begin
          want = expected_px_q.pop_front();
          check_field("red_out", want.red, red_out);
          check_field("green_out", want.green, green_out);
          check_field("blue_out", want.blue, blue_out);
          check_field("status", want.status, status);
        end
        rx_taken++;
        // every third stretch of results takes no random stall
        rx_wait = ((rx_taken / 40) % 3 == 1) ? 0 : $urandom_range(0, 11);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_ready <= !rx_hold && rx_wait == 0;
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin : rx_hold_off
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [COMP_W-1:0] rand_comp();
    return ($urandom_range(0, 1) == 1) ? COMP_W'($urandom) : COMP_W'($urandom_range(0, 300));
  endfunction

  // mostly modest weights so sums land inside the range, some wild ones
  function automatic logic [COEFF_W-1:0] rand_coeff();
    case ($urandom_range(0, 4))
      0: return COEFF_W'($urandom);
      1: return -COEFF_W'($urandom_range(0, 2048));
      default: return COEFF_W'($urandom_range(0, 2048));
    endcase
  endfunction

  task automatic push_req(input logic [1:0] rop, input int rcol, input int rrow,
                          input logic [COMP_W-1:0] r, input logic [COMP_W-1:0] g,
                          input logic [COMP_W-1:0] b, input logic [COEFF_W-1:0] c);
    conv_req_t rq;
    rq.op = rop;
    rq.col = COORD_W'(rcol);
    rq.row = COORD_W'(rrow);
    rq.red = r;
    rq.green = g;
    rq.blue = b;
    rq.coeff = c;
    // back-to-back stretches alternate with idling ones
    rq.gap = ((gen_count % 90) < 30) ? 0 : $urandom_range(0, 11);
    rq.drain = ($urandom_range(0, 59) == 0);
    if (rop == OP_WRITE_PIX && rcol < cur_w() && rrow < cur_h())
      pix_known[rrow * MAX_WIDTH + rcol] = 1'b1;
    req_q.push_back(rq);
    gen_count++;
  endtask

  // write any pixel the coming compute would read before it is ever written
  task automatic cover_taps(input int ccol, input int crow);
    int x, y;
    for (int i = 0; i < eff_dim(int'(sh_kw), MAX_KERNEL); i++) begin
      for (int j = 0; j < eff_dim(int'(sh_kh), MAX_KERNEL); j++) begin
        x = clip(ccol - int'(sh_cx) + i, 0, cur_w() - 1);
        y = clip(crow - int'(sh_cy) + j, 0, cur_h() - 1);
        if (!pix_known[y * MAX_WIDTH + x])
          push_req(OP_WRITE_PIX, x, y, rand_comp(), rand_comp(), rand_comp(), rand_coeff());
      end
    end
  endtask

  task automatic pick_coord(input bit outside, output int pcol, output int prow);
    int w, h;
    w = cur_w();
    h = cur_h();
    pcol = $urandom_range(0, w - 1);
    prow = $urandom_range(0, h - 1);
    if (outside) begin
      if (w < MAX_WIDTH && (h == MAX_HEIGHT || $urandom_range(0, 1) == 1))
        pcol = $urandom_range(w, COORD_MAX);
      else if (h < MAX_HEIGHT)
        prow = $urandom_range(h, COORD_MAX);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_IMAGE_WIDTH:    sh_iw = val;
      REG_IMAGE_HEIGHT:   sh_ih = val;
      REG_KERNEL_WIDTH:   sh_kw = val[KDIM_W-1:0];
      REG_KERNEL_HEIGHT:  sh_kh = val[KDIM_W-1:0];
      REG_CENTER_X:       sh_cx = val[KDIM_W-1:0];
      REG_CENTER_Y:       sh_cy = val[KDIM_W-1:0];
      REG_BYTES_PER_COMP: sh_bpc = val[BPC_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // narrow registers get junk in the unused upper data bits
  task automatic set_config(input int iw, input int ih, input int kw, input int kh,
                            input int cx, input int cy, input int bpc);
    write_reg(REG_NONE, CFG_DATA_W'($urandom_range(0, 127)));
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(iw));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(ih));
    write_reg(REG_KERNEL_WIDTH, {4'($urandom_range(0, 15)), 3'(kw)});
    write_reg(REG_KERNEL_HEIGHT, {4'($urandom_range(0, 15)), 3'(kh)});
    write_reg(REG_CENTER_X, {4'($urandom_range(0, 15)), 3'(cx)});
    write_reg(REG_CENTER_Y, {4'($urandom_range(0, 15)), 3'(cy)});
    write_reg(REG_BYTES_PER_COMP, {5'($urandom_range(0, 31)), 2'(bpc)});
  endtask

  // sender pause: nothing queued, nothing offered, nothing outstanding
  // sampled on the falling edge so the driver and monitor have settled
  task automatic wait_idle();
    do @(negedge clk);
    while (req_q.size() != 0 || have_next || in_valid || expected_px_q.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int pcol, prow, pick, phase_end;
    bit roomy, outside;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: 64x64 image, single-tap kernel, 8-bit components
    push_req(OP_LOAD_COEFF, 0, 0, '0, '0, '0, 16'sd4096);
    push_req(OP_LOAD_COEFF, 7, 0, '0, '0, '0, 16'sd100);         // kernel column off the store
    push_req(OP_LOAD_COEFF, 63, 63, '1, '1, '1, -16'sd32768);     // both kernel coords off
    push_req(OP_WRITE_PIX, 0, 0, 16'hFFFF, 16'hFFFF, 16'h0000, '0); // saturates to 8 bits
    push_req(OP_WRITE_PIX, 63, 63, 16'h00FF, 16'h0100, 16'h8000, '1);
    push_req(OP_COMPUTE, 0, 0, '0, '0, '0, '0);
    push_req(OP_COMPUTE, 63, 63, '0, '0, '0, '0);
    push_req(OP_UNUSED, 63, 63, '1, '1, '1, '1);
    wait_idle();

    // tiny 3x2 image, 3x3 kernel centered, 16-bit components
    set_config(3, 2, 3, 3, 1, 1, 2);
    push_req(OP_WRITE_PIX, 3, 0, '1, '1, '1, '0);                 // column past the image
    push_req(OP_WRITE_PIX, 0, 2, '1, '1, '1, '0);                 // row past the image
    push_req(OP_WRITE_PIX, 0, 0, 16'hFFFF, 16'h0000, 16'h1234, '0);
    push_req(OP_WRITE_PIX, 1, 0, 16'h0000, 16'hFFFF, 16'h8000, '0);
    push_req(OP_WRITE_PIX, 2, 0, 16'h0001, 16'h7FFF, 16'hFFFF, '0);
    push_req(OP_WRITE_PIX, 0, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, '0);
    push_req(OP_WRITE_PIX, 1, 1, 16'h0000, 16'h0000, 16'h0000, '0);
    push_req(OP_WRITE_PIX, 2, 1, 16'h00FF, 16'h0100, 16'hAAAA, '0);
    push_req(OP_LOAD_COEFF, 1, 1, '0, '0, '0, 16'sd32767);
    push_req(OP_LOAD_COEFF, 2, 2, '0, '0, '0, -16'sd32768);
    push_req(OP_LOAD_COEFF, 6, 6, '0, '0, '0, 16'sd1234);
    push_req(OP_COMPUTE, 0, 0, '0, '0, '0, '0);
    push_req(OP_COMPUTE, 2, 1, '0, '0, '0, '0);
    push_req(OP_COMPUTE, 3, 1, '0, '0, '0, '0);                   // outside the image
    push_req(OP_COMPUTE, 0, 2, '0, '0, '0, '0);
    wait_idle();

    // random phases, each under its own settings, extremes among them
    for (int p = 0; p < 13; p++) begin
      case (p)
        2:  set_config(127, 64, 7, 7, 7, 6, 3);
        5:  set_config(0, 0, 7, 0, 0, 7, 0);
        8:  set_config(64, 1, 1, 7, 3, 3, 2);
        11: set_config(1, 64, 7, 7, 6, 0, 1);
        default: set_config($urandom_range(1, 10), $urandom_range(1, 10),
                            $urandom_range(1, 7), $urandom_range(1, 7),
                            $urandom_range(0, 7), $urandom_range(0, 7),
                            $urandom_range(0, 3));
      endcase
      if (p == 1) hold_go = 1'b1;
      // big images make tap filling costly, so computes get rarer there
      roomy = cur_w() * cur_h() > 100;
      phase_end = gen_count + 46;
      while (gen_count < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
          pcol = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_KERNEL, COORD_MAX)
                                              : $urandom_range(0, MAX_KERNEL - 1);
          prow = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_KERNEL, COORD_MAX)
                                              : $urandom_range(0, MAX_KERNEL - 1);
          push_req(OP_LOAD_COEFF, pcol, prow, rand_comp(), rand_comp(), rand_comp(),
                   rand_coeff());
        end else if (pick < 50 || (pick < 95 && roomy && $urandom_range(0, 7) != 0)) begin
          pick_coord($urandom_range(0, 4) == 0, pcol, prow);
          push_req(OP_WRITE_PIX, pcol, prow, rand_comp(), rand_comp(), rand_comp(),
                   rand_coeff());
        end else if (pick < 95) begin
          outside = ($urandom_range(0, 6) == 0);
          pick_coord(outside, pcol, prow);
          if (pcol < cur_w() && prow < cur_h()) cover_taps(pcol, prow);
          push_req(OP_COMPUTE, pcol, prow, rand_comp(), rand_comp(), rand_comp(),
                   rand_coeff());
        end else begin
          push_req(OP_UNUSED, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                   rand_comp(), rand_comp(), rand_comp(), rand_coeff());
        end
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// File: filelist.f
design/rkc_pkg.sv
design/rgb_kernel_convolution_core.sv
dv/rgb_kernel_convolution_core_test.sv
